@@ rtl/vubrf_pkg.sv @@
// ----------------------------------------------------------------------------
// vubrf_pkg
// Shared types, codes and address helpers for the video unit register file.
// ----------------------------------------------------------------------------
package vubrf_pkg;

  // Memory sizes
  localparam int SPRITE_MEM_BYTES   = 256;
  localparam int PATTERN_BANK_BYTES = 4096;
  localparam int NAMETABLE_BYTES    = 1024;
  localparam int PALETTE_ENTRIES    = 32;

  localparam int SPR_AW = $clog2(SPRITE_MEM_BYTES);
  localparam int PAT_AW = $clog2(2 * PATTERN_BANK_BYTES);
  localparam int NT_AW  = $clog2(2 * NAMETABLE_BYTES);
  localparam int NTB_AW = $clog2(NAMETABLE_BYTES);
  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

  // Video bus address width and palette window start
  localparam int                BUS_AW   = 14;
  localparam logic [BUS_AW-1:0] PAL_BASE = 14'h3F00;

  // Palette value masks
  localparam logic [7:0] PAL_MASK_GRAY  = 8'h30;
  localparam logic [7:0] PAL_MASK_COLOR = 8'h3F;

  // VRAM address steps
  localparam logic [15:0] VRAM_STEP_ROW = 16'd32;
  localparam logic [15:0] VRAM_STEP_COL = 16'd1;

  // Request kinds
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_VBLANK = 2'd2;
  localparam logic [1:0] KIND_FRAME  = 2'd3;

  // Register numbers
  localparam logic [2:0] REG_CONTROL = 3'd0;
  localparam logic [2:0] REG_MASK    = 3'd1;
  localparam logic [2:0] REG_STATUS  = 3'd2;
  localparam logic [2:0] REG_SPR_ADR = 3'd3;
  localparam logic [2:0] REG_SPR_DAT = 3'd4;
  localparam logic [2:0] REG_SCROLL  = 3'd5;
  localparam logic [2:0] REG_VADDR   = 3'd6;
  localparam logic [2:0] REG_DATA    = 3'd7;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Nametable index with mirroring: vertical uses bit 10, horizontal bit 11
  function automatic logic [NT_AW-1:0] nt_index(input logic [BUS_AW-1:0] a,
                                                input logic mode);
    logic table_sel;
    table_sel = mode ? a[11] : a[10];
    return {table_sel, a[NTB_AW-1:0]};
  endfunction

  // Palette index with the backdrop mirrors folded onto entries 0, 4, 8, 12
  function automatic logic [PAL_AW-1:0] pal_index(input logic [BUS_AW-1:0] a);
    logic [PAL_AW-1:0] i;
    i = a[PAL_AW-1:0];
    if (i[4] && (i[1:0] == 2'b00)) begin
      i[4] = 1'b0;
    end
    return i;
  endfunction

endpackage

@@ rtl/video_unit_bus_register_file_core.sv @@
// ----------------------------------------------------------------------------
// video_unit_bus_register_file_core
// Processor-side register interface of a video unit with its sprite, pattern,
// nametable and palette memories.
// ----------------------------------------------------------------------------
// For each request, the accept edge launches the memory reads, and the next
// cycle executes the request, writes the memories back and registers the
// result. done is high for exactly one cycle with read_data and nmi_request;
// the receiver cannot stall it. busy is high during the execute cycle only,
// so a new request can be accepted in the same cycle that the previous result
// is shown, but not while one executes. The user must write mirroring_mode
// through cfg_write/cfg_data only while no request is in flight; the block
// does not enforce this. Memory contents are undefined until written; no
// clearing pass runs after reset.
module video_unit_bus_register_file_core
  import vubrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] kind,
  input  logic [2:0] reg_select,
  input  logic [7:0] write_data,
  output logic       done,
  output logic [7:0] read_data,
  output logic       nmi_request
);

  // Control and register state
  state_t      state, state_next;
  logic        mirroring_mode;
  logic [7:0]  control_bits, control_bits_next;
  logic [7:0]  render_mask_bits, render_mask_bits_next;
  logic [2:0]  status_flags, status_flags_next;
  logic [7:0]  sprite_mem_address, sprite_mem_address_next;
  logic        write_toggle, write_toggle_next;
  logic [2:0]  fine_scroll_x, fine_scroll_x_next;
  logic [15:0] temp_vram_address, temp_vram_address_next;
  logic [15:0] vram_address, vram_address_next;
  logic [7:0]  read_buffer, read_buffer_next;

  // Captured request
  logic [1:0]  req_kind;
  logic [2:0]  req_reg;
  logic [7:0]  req_data;

  // Memories
  logic [7:0] spr_mem [SPRITE_MEM_BYTES];
  logic [7:0] pat_mem [2 * PATTERN_BANK_BYTES];
  logic [7:0] nt_mem  [2 * NAMETABLE_BYTES];
  logic [7:0] pal_mem [PALETTE_ENTRIES];
  logic [7:0] spr_q, pat_q, nt_q, pal_q;

  logic              accept;
  logic [BUS_AW-1:0] bus_addr;
  logic [NT_AW-1:0]  nt_addr;
  logic [PAL_AW-1:0] pal_addr;
  logic              in_pattern, in_palette;
  logic [7:0]        fresh;
  logic              spr_we, pat_we, nt_we, pal_we;
  logic [7:0]        rd_value;
  logic              nmi_value;

  assign accept   = start && !busy;
  assign bus_addr = vram_address[BUS_AW-1:0];
  assign nt_addr  = nt_index(bus_addr, mirroring_mode);
  assign pal_addr = pal_index(bus_addr);
  assign in_pattern = !bus_addr[BUS_AW-1];
  assign in_palette = (bus_addr >= PAL_BASE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    case (state)
      ST_EXEC: busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  // Hold the request and the mirroring register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      mirroring_mode <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) mirroring_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= kind;
      req_reg  <= reg_select;
      req_data <= write_data;
    end
  end

  // Launch memory reads on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      spr_q <= spr_mem[sprite_mem_address];
      pat_q <= pat_mem[bus_addr[PAT_AW-1:0]];
      nt_q  <= nt_mem[nt_addr];
      pal_q <= pal_mem[pal_addr];
    end
  end

  // Write memories back in the execute cycle
  always_ff @(posedge clk) begin
    if (spr_we) spr_mem[sprite_mem_address] <= req_data;
    if (pat_we) pat_mem[bus_addr[PAT_AW-1:0]] <= req_data;
    if (nt_we)  nt_mem[nt_addr] <= req_data;
    if (pal_we) pal_mem[pal_addr] <= req_data;
  end

  // Select the fresh value from the video bus
  always_comb begin
    if (in_pattern) begin
      fresh = pat_q;
    end else if (!in_palette) begin
      fresh = nt_q;
    end else begin
      fresh = pal_q & (render_mask_bits[0] ? PAL_MASK_GRAY : PAL_MASK_COLOR);
    end
  end

  // Execute the request
  always_comb begin
    logic exec;
    logic [15:0] step;
    exec = (state == ST_EXEC);
    step = control_bits[2] ? VRAM_STEP_ROW : VRAM_STEP_COL;

    control_bits_next       = control_bits;
    render_mask_bits_next   = render_mask_bits;
    status_flags_next       = status_flags;
    sprite_mem_address_next = sprite_mem_address;
    write_toggle_next       = write_toggle;
    fine_scroll_x_next      = fine_scroll_x;
    temp_vram_address_next  = temp_vram_address;
    vram_address_next       = vram_address;
    read_buffer_next        = read_buffer;
    spr_we    = 1'b0;
    pat_we    = 1'b0;
    nt_we     = 1'b0;
    pal_we    = 1'b0;
    rd_value  = 8'h00;
    nmi_value = 1'b0;

    if (exec) begin
      case (req_kind)
        KIND_READ: begin
          case (req_reg)
            REG_STATUS: begin
              rd_value             = {status_flags, read_buffer[4:0]};
              status_flags_next[2] = 1'b0;
              write_toggle_next    = 1'b0;
            end
            REG_SPR_DAT: rd_value = spr_q;
            REG_DATA: begin
              rd_value          = in_palette ? fresh : read_buffer;
              read_buffer_next  = fresh;
              vram_address_next = vram_address + step;
            end
            default: rd_value = 8'h00;
          endcase
        end
        KIND_WRITE: begin
          case (req_reg)
            REG_CONTROL: begin
              control_bits_next             = req_data;
              temp_vram_address_next[11:10] = req_data[1:0];
            end
            REG_MASK:    render_mask_bits_next = req_data;
            REG_SPR_ADR: sprite_mem_address_next = req_data;
            REG_SPR_DAT: begin
              spr_we                  = 1'b1;
              sprite_mem_address_next = sprite_mem_address + 8'd1;
            end
            REG_SCROLL: begin
              if (!write_toggle) begin
                fine_scroll_x_next          = req_data[2:0];
                temp_vram_address_next[4:0] = req_data[7:3];
                write_toggle_next           = 1'b1;
              end else begin
                temp_vram_address_next[14:12] = req_data[2:0];
                temp_vram_address_next[9:5]   = req_data[7:3];
                write_toggle_next             = 1'b0;
              end
            end
            REG_VADDR: begin
              if (!write_toggle) begin
                temp_vram_address_next = {2'b00, req_data[5:0], temp_vram_address[7:0]};
                write_toggle_next      = 1'b1;
              end else begin
                temp_vram_address_next = {temp_vram_address[15:8], req_data};
                vram_address_next      = {temp_vram_address[15:8], req_data};
                write_toggle_next      = 1'b0;
              end
            end
            REG_DATA: begin
              pat_we            = in_pattern;
              nt_we             = !in_pattern && !in_palette;
              pal_we            = in_palette;
              vram_address_next = vram_address + step;
            end
            default: ;
          endcase
        end
        KIND_VBLANK: begin
          status_flags_next[2] = 1'b1;
          nmi_value            = control_bits[7];
        end
        default: status_flags_next = 3'b000;
      endcase
    end
  end

  // Advance register state
  always_ff @(posedge clk) begin
    if (rst) begin
      control_bits       <= '0;
      render_mask_bits   <= '0;
      status_flags       <= '0;
      sprite_mem_address <= '0;
      write_toggle       <= 1'b0;
      fine_scroll_x      <= '0;
      temp_vram_address  <= '0;
      vram_address       <= '0;
      read_buffer        <= '0;
    end else begin
      control_bits       <= control_bits_next;
      render_mask_bits   <= render_mask_bits_next;
      status_flags       <= status_flags_next;
      sprite_mem_address <= sprite_mem_address_next;
      write_toggle       <= write_toggle_next;
      fine_scroll_x      <= fine_scroll_x_next;
      temp_vram_address  <= temp_vram_address_next;
      vram_address       <= vram_address_next;
      read_buffer        <= read_buffer_next;
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      read_data   <= 8'h00;
      nmi_request <= 1'b0;
    end else begin
      done        <= (state == ST_EXEC);
      read_data   <= rd_value;
      nmi_request <= nmi_value;
    end
  end

  // Checks
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_EXEC))
    else $error("result without an executed request");

  a_accept_to_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not enter execute");

  a_nmi_with_done: assert property (@(posedge clk) disable iff (rst)
    nmi_request |-> done)
    else $error("nmi request outside a result");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> (!busy && done))
    else $error("execute did not finish in one cycle");

endmodule

@@ verif/vubrf_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vubrf_result_checker
// Watches the request and result channels of the video unit register file,
// predicts every result from its own copy of the register and memory state,
// and compares each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module vubrf_result_checker
  import vubrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  kind,
  input  logic [2:0]  reg_select,
  input  logic [7:0]  write_data,
  input  logic        done,
  input  logic [7:0]  read_data,
  input  logic        nmi_request,
  output int unsigned pending,
  output int          fail_count
);

  typedef struct packed {
    logic [7:0] data;
    logic       nmi;
  } access_result_t;

  // Shadow copy of the block state
  logic        mirror_horizontal;
  logic [7:0]  ctrl_reg;
  logic [7:0]  mask_reg;
  logic [2:0]  flags;          // [2] vblank, [1] sprite zero hit, [0] overflow
  logic [7:0]  sprite_ptr;
  logic [7:0]  oam [SPRITE_MEM_BYTES];
  logic        addr_latch;
  logic [2:0]  fine_x;
  logic [15:0] t_addr;
  logic [15:0] v_addr;
  logic [7:0]  data_buffer;
  logic [7:0]  pattern_mem [2*PATTERN_BANK_BYTES];
  logic [7:0]  nametable_mem [2*NAMETABLE_BYTES];
  logic [7:0]  palette_mem [PALETTE_ENTRIES];

  access_result_t expected_results[$];
  int             mismatches = 0;

  // Pick the physical nametable from the mirroring setting
  function automatic logic [NT_AW-1:0] nametable_slot(input logic [BUS_AW-1:0] a);
    logic upper;
    upper = mirror_horizontal ? a[11] : a[10];
    return {upper, a[NTB_AW-1:0]};
  endfunction

  // Fold the backdrop mirrors at 0x10/0x14/0x18/0x1C down by 16
  function automatic logic [PAL_AW-1:0] palette_slot(input logic [BUS_AW-1:0] a);
    logic [PAL_AW-1:0] slot;
    slot = a[PAL_AW-1:0];
    if ((slot & 5'h13) == 5'h10) slot = slot & 5'h0F;
    return slot;
  endfunction

  function automatic logic [7:0] video_read(input logic [BUS_AW-1:0] a);
    if (a < 2*PATTERN_BANK_BYTES) return pattern_mem[a[PAT_AW-1:0]];
    if (a < PAL_BASE) return nametable_mem[nametable_slot(a)];
    return palette_mem[palette_slot(a)] & (mask_reg[0] ? PAL_MASK_GRAY : PAL_MASK_COLOR);
  endfunction

  function automatic void video_write(input logic [BUS_AW-1:0] a, input logic [7:0] d);
    if (a < 2*PATTERN_BANK_BYTES) pattern_mem[a[PAT_AW-1:0]] = d;
    else if (a < PAL_BASE) nametable_mem[nametable_slot(a)] = d;
    else palette_mem[palette_slot(a)] = d;
  endfunction

  // Advance the VRAM address by a row or a column
  function automatic void step_vram();
    v_addr = v_addr + (ctrl_reg[2] ? VRAM_STEP_ROW : VRAM_STEP_COL);
  endfunction

  // Apply one request to the shadow state and return its result
  function automatic access_result_t predict_access(input logic [1:0] k,
                                                    input logic [2:0] r,
                                                    input logic [7:0] d);
    access_result_t   res;
    logic [BUS_AW-1:0] a;
    res = '0;
    a   = v_addr[BUS_AW-1:0];
    case (k)
      KIND_READ: begin
        case (r)
          REG_STATUS: begin
            res.data   = {flags, data_buffer[4:0]};
            flags[2]   = 1'b0;
            addr_latch = 1'b0;
          end
          REG_SPR_DAT: res.data = oam[sprite_ptr];
          REG_DATA: begin
            // Buffered below the palette window, direct inside it
            res.data    = data_buffer;
            data_buffer = video_read(a);
            if (a >= PAL_BASE) res.data = data_buffer;
            step_vram();
          end
          default: ;
        endcase
      end
      KIND_WRITE: begin
        case (r)
          REG_CONTROL: begin
            ctrl_reg       = d;
            t_addr[11:10]  = d[1:0];
          end
          REG_MASK:    mask_reg = d;
          REG_SPR_ADR: sprite_ptr = d;
          REG_SPR_DAT: begin
            oam[sprite_ptr] = d;
            sprite_ptr      = sprite_ptr + 8'd1;
          end
          REG_SCROLL: begin
            if (!addr_latch) begin
              fine_x      = d[2:0];
              t_addr[4:0] = d[7:3];
            end else begin
              t_addr[14:12] = d[2:0];
              t_addr[9:5]   = d[7:3];
            end
            addr_latch = !addr_latch;
          end
          REG_VADDR: begin
            if (!addr_latch) begin
              t_addr = {2'b00, d[5:0], t_addr[7:0]};
            end else begin
              t_addr[7:0] = d;
              v_addr      = t_addr;
            end
            addr_latch = !addr_latch;
          end
          REG_DATA: begin
            video_write(a, d);
            step_vram();
          end
          default: ;
        endcase
      end
      KIND_VBLANK: begin
        flags[2] = 1'b1;
        res.nmi  = ctrl_reg[7];
      end
      default: flags = '0;
    endcase
    return res;
  endfunction

  // Compare strobed results, then predict for the request accepted at this edge
  always @(posedge clk) begin
    access_result_t want;
    if (rst) begin
      mirror_horizontal = 1'b0;
      ctrl_reg          = '0;
      mask_reg          = '0;
      flags             = '0;
      sprite_ptr        = '0;
      addr_latch        = 1'b0;
      fine_x            = '0;
      t_addr            = '0;
      v_addr            = '0;
      data_buffer       = '0;
      expected_results.delete();
    end else begin
      if (cfg_write) mirror_horizontal = cfg_data;
      if (done) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, actual read_data %02h nmi_request %0b",
                   $time, read_data, nmi_request);
        end else begin
          want = expected_results.pop_front();
          if (read_data !== want.data) begin
            mismatches++;
            $display("%0t: read_data mismatch, expected %02h, actual %02h",
                     $time, want.data, read_data);
          end
          if (nmi_request !== want.nmi) begin
            mismatches++;
            $display("%0t: nmi_request mismatch, expected %0b, actual %0b",
                     $time, want.nmi, nmi_request);
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(predict_access(kind, reg_select, write_data));
      end
    end
    pending    <= expected_results.size();
    fail_count <= mismatches;
  end

endmodule

@@ verif/tb_video_unit_bus_register_file_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_video_unit_bus_register_file_core
// Drives register accesses and vblank/frame events into the video unit
// register file: first the palette, the sprite memory and a few pattern bytes
// are written, then a short directed list, then randomized access sequences
// under both mirroring settings. Data-port reads only revisit written words.
// ----------------------------------------------------------------------------
module tb_video_unit_bus_register_file_core;
  import vubrf_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_REQUESTS = 390;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_data;
  logic        start;
  logic        busy;
  logic [1:0]  kind;
  logic [2:0]  reg_select;
  logic [7:0]  write_data;
  logic        done;
  logic [7:0]  read_data;
  logic        nmi_request;

  int unsigned pending_results;
  int          fail_count;
  int unsigned requests_sent = 0;
  int unsigned no_gap_run = 0;
  int unsigned idle_cycles = 0;

  video_unit_bus_register_file_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .reg_select  (reg_select),
    .write_data  (write_data),
    .done        (done),
    .read_data   (read_data),
    .nmi_request (nmi_request)
  );

  vubrf_result_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .reg_select  (reg_select),
    .write_data  (write_data),
    .done        (done),
    .read_data   (read_data),
    .nmi_request (nmi_request),
    .pending     (pending_results),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort when no request is taken for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly back-to-back, some short gaps, a few long ones, plus gapless runs
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_gap_run != 0) begin
      no_gap_run--;
      return 0;
    end
    if (roll < 3) begin
      no_gap_run = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one request and hold it until the block takes it
  task automatic send_request(input logic [1:0] k, input logic [2:0] r,
                              input logic [7:0] d);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    kind       <= k;
    reg_select <= r;
    write_data <= d;
    do @(posedge clk); while (busy);
    requests_sent++;
  endtask

  // Drop start and wait for every predicted result to come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic set_mirroring(input logic horizontal);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data  <= horizontal;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Two address writes; the toggle must be clear on entry
  task automatic set_vram_address(input logic [15:0] a);
    send_request(KIND_WRITE, REG_VADDR, a[15:8]);
    send_request(KIND_WRITE, REG_VADDR, a[7:0]);
  endtask

  // One randomized sequence of related requests
  task automatic random_sequence();
    int unsigned roll;
    int unsigned n;
    logic [15:0] a;
    logic [1:0]  k;
    logic [2:0]  r;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      // Data port burst: write a run at a fresh address, then read it back
      send_request(KIND_READ, REG_STATUS, 8'($urandom_range(0, 255)));
      a = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 3) == 0) a[13:8] = 6'h3F;
      n = $urandom_range(1, 8);
      set_vram_address(a);
      repeat (n) send_request(KIND_WRITE, REG_DATA, 8'($urandom_range(0, 255)));
      set_vram_address(a);
      repeat (n) send_request(KIND_READ, REG_DATA, 8'($urandom_range(0, 255)));
    end else if (roll < 45) begin
      send_request(KIND_READ, REG_STATUS, 8'($urandom_range(0, 255)));
      send_request(KIND_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
      send_request(KIND_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
    end else if (roll < 60) begin
      send_request(KIND_WRITE, REG_SPR_ADR, 8'($urandom_range(0, 255)));
      n = $urandom_range(1, 6);
      repeat (n) begin
        k = ($urandom_range(0, 1) != 0) ? KIND_READ : KIND_WRITE;
        send_request(k, REG_SPR_DAT, 8'($urandom_range(0, 255)));
      end
    end else if (roll < 70) begin
      if ($urandom_range(0, 1) != 0) begin
        send_request(KIND_WRITE, REG_CONTROL, 8'($urandom_range(0, 255)));
      end else begin
        send_request(KIND_WRITE, REG_MASK, 8'($urandom_range(0, 255)));
      end
    end else if (roll < 85) begin
      // Vblank, frame clear and status reads in random order
      n = $urandom_range(1, 5);
      repeat (n) begin
        case ($urandom_range(0, 2))
          0: send_request(KIND_VBLANK, 3'($urandom_range(0, 7)),
                          8'($urandom_range(0, 255)));
          1: send_request(KIND_FRAME, 3'($urandom_range(0, 7)),
                          8'($urandom_range(0, 255)));
          default: send_request(KIND_READ, REG_STATUS, 8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      // Unstructured noise; data-port reads only follow a write run
      n = $urandom_range(1, 4);
      repeat (n) begin
        k = 2'($urandom_range(0, 3));
        r = 3'($urandom_range(0, 7));
        if ((k == KIND_READ) && (r == REG_DATA)) k = KIND_WRITE;
        send_request(k, r, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int unsigned phase_end;
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_data   = 1'b0;
    start      = 1'b0;
    kind       = KIND_READ;
    reg_select = REG_CONTROL;
    write_data = 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Write the first pattern bytes, the whole palette and the sprite memory
    set_mirroring(1'b0);
    set_vram_address(16'h0000);
    repeat (4) send_request(KIND_WRITE, REG_DATA, 8'($urandom_range(0, 255)));
    set_vram_address(16'h3F00);
    repeat (PALETTE_ENTRIES) begin
      send_request(KIND_WRITE, REG_DATA, 8'($urandom_range(0, 255)));
    end
    send_request(KIND_WRITE, REG_SPR_ADR, 8'h00);
    repeat (SPRITE_MEM_BYTES) begin
      send_request(KIND_WRITE, REG_SPR_DAT, 8'($urandom_range(0, 255)));
    end

    // Step the VRAM address past the top of the video bus, by column and by row
    set_vram_address(16'h3FFE);
    repeat (4) send_request(KIND_READ, REG_DATA, 8'h00);
    send_request(KIND_WRITE, REG_CONTROL, 8'h04);
    set_vram_address(16'h3FE0);
    send_request(KIND_READ, REG_DATA, 8'h00);
    send_request(KIND_READ, REG_DATA, 8'h00);

    // Directed: write-only reads, status write, nmi, flags, palette, wrap cases
    send_request(KIND_READ, REG_CONTROL, 8'hFF);
    send_request(KIND_READ, REG_MASK, 8'hFF);
    send_request(KIND_READ, REG_SPR_ADR, 8'hFF);
    send_request(KIND_READ, REG_SCROLL, 8'hFF);
    send_request(KIND_READ, REG_VADDR, 8'hFF);
    send_request(KIND_WRITE, REG_STATUS, 8'hFF);
    send_request(KIND_WRITE, REG_CONTROL, 8'h80);
    send_request(KIND_VBLANK, REG_CONTROL, 8'h00);
    send_request(KIND_READ, REG_STATUS, 8'h00);
    send_request(KIND_VBLANK, REG_DATA, 8'hFF);
    send_request(KIND_FRAME, REG_DATA, 8'hFF);
    send_request(KIND_WRITE, REG_CONTROL, 8'h00);
    send_request(KIND_VBLANK, REG_CONTROL, 8'h00);
    set_vram_address(16'h3F10);
    send_request(KIND_READ, REG_DATA, 8'h00);
    send_request(KIND_WRITE, REG_MASK, 8'h01);
    send_request(KIND_READ, REG_DATA, 8'h00);
    send_request(KIND_WRITE, REG_MASK, 8'h00);
    set_vram_address(16'hFFFF);
    send_request(KIND_READ, REG_DATA, 8'h00);
    send_request(KIND_WRITE, REG_SCROLL, 8'hFF);
    send_request(KIND_WRITE, REG_SCROLL, 8'h00);
    send_request(KIND_WRITE, REG_SPR_ADR, 8'hFF);
    send_request(KIND_WRITE, REG_SPR_DAT, 8'hAB);
    send_request(KIND_READ, REG_SPR_DAT, 8'h00);

    // Random phases alternating horizontal and vertical mirroring
    for (int phase = 0; phase < 4; phase++) begin
      set_mirroring(phase % 2 == 0);
      phase_end = requests_sent + PHASE_REQUESTS;
      while (requests_sent < phase_end) random_sequence();
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
